### design/hmq_pkg.sv
package hmq_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned TOTAL_W = 7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_COMPARE,
		ST_FINISH
	} hmq_state_t;

	typedef struct packed {
		logic take;
		logic write_hole;
		logic write_val;
		logic load_rsp;
	} hmq_cmd_t;

	typedef struct packed {
		logic op_clear;
		logic heap_full;
		logic pos_zero;
		logic greater;
		logic rsp_busy;
	} hmq_status_t;

endpackage

### design/hmq_req_if.sv
interface hmq_req_if;
	logic                                valid;
	logic                                ready;
	logic                                operation;
	logic signed [hmq_pkg::VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

### design/hmq_rsp_if.sv
interface hmq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                accepted;
	logic signed [hmq_pkg::VALUE_W-1:0] top_value;
	logic                                top_valid;
	logic [hmq_pkg::TOTAL_W-1:0]         item_total;
	logic                                is_full;

	modport source (output valid, output accepted, output top_value, output top_valid,
		output item_total, output is_full, input ready);
	modport sink (input valid, input accepted, input top_value, input top_valid,
		input item_total, input is_full, output ready);
endinterface

### design/hmq_ctrl.sv
module hmq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  hmq_pkg::hmq_status_t status,
	output hmq_pkg::hmq_cmd_t    cmd
);

	hmq_pkg::hmq_state_t state_q;
	hmq_pkg::hmq_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hmq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		req_ready  = 1'b0;
		cmd        = '0;
		case (state_q)
			hmq_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					if (status.op_clear || status.heap_full) begin
						state_next = hmq_pkg::ST_FINISH;
					end else begin
						state_next = hmq_pkg::ST_CHECK;
					end
				end
			end
			hmq_pkg::ST_CHECK: begin
				if (status.pos_zero) begin
					cmd.write_val = 1'b1;
					state_next    = hmq_pkg::ST_FINISH;
				end else begin
					state_next = hmq_pkg::ST_COMPARE;
				end
			end
			hmq_pkg::ST_COMPARE: begin
				if (status.greater) begin
					cmd.write_hole = 1'b1;
					state_next     = hmq_pkg::ST_CHECK;
				end else begin
					cmd.write_val = 1'b1;
					state_next    = hmq_pkg::ST_FINISH;
				end
			end
			hmq_pkg::ST_FINISH: begin
				if (!status.rsp_busy) begin
					cmd.load_rsp = 1'b1;
					state_next   = hmq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = hmq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### design/hmq_datapath.sv
module hmq_datapath #(
	parameter int unsigned HEAP_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_operation,
	input  logic signed [hmq_pkg::VALUE_W-1:0] req_value,
	input  logic                                rsp_ready,
	input  hmq_pkg::hmq_cmd_t                   cmd,
	output hmq_pkg::hmq_status_t                status,
	output logic                                rsp_valid,
	output logic                                rsp_accepted,
	output logic signed [hmq_pkg::VALUE_W-1:0] rsp_top_value,
	output logic                                rsp_top_valid,
	output logic [hmq_pkg::TOTAL_W-1:0]         rsp_item_total,
	output logic                                rsp_is_full
);

	localparam int unsigned IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

	logic signed [hmq_pkg::VALUE_W-1:0] heap_mem_q [HEAP_DEPTH];
	logic signed [hmq_pkg::VALUE_W-1:0] rd_q;
	logic signed [hmq_pkg::VALUE_W-1:0] val_q;
	logic signed [hmq_pkg::VALUE_W-1:0] top_q;
	logic [CW-1:0]                      count_q;
	logic [IW-1:0]                      pos_q;
	logic                               acc_q;
	logic                               rsp_valid_q;
	logic [IW-1:0]                      parent_idx;
	logic                               heap_full;
	logic                               mem_we;
	logic signed [hmq_pkg::VALUE_W-1:0] mem_wdata;

	assign parent_idx = (pos_q - IW'(1)) >> 1;
	assign heap_full  = (count_q == CW'(HEAP_DEPTH));
	assign mem_we     = cmd.write_hole || cmd.write_val;
	assign mem_wdata  = cmd.write_hole ? rd_q : val_q;

	assign status.op_clear  = (req_operation == hmq_pkg::OP_CLEAR);
	assign status.heap_full = heap_full;
	assign status.pos_zero  = (pos_q == '0);
	assign status.greater   = (val_q > rd_q);
	assign status.rsp_busy  = rsp_valid_q && !rsp_ready;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem_q[pos_q] <= mem_wdata;
		end
		rd_q <= heap_mem_q[parent_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			acc_q <= (req_operation == hmq_pkg::OP_CLEAR) || !heap_full;
			val_q <= req_value;
			pos_q <= count_q[IW-1:0];
		end else if (cmd.write_hole) begin
			pos_q <= parent_idx;
		end
		if (cmd.write_val && (pos_q == '0)) begin
			top_q <= val_q;
		end
		if (cmd.load_rsp) begin
			rsp_accepted   <= acc_q;
			rsp_top_value  <= (count_q != '0) ? top_q : '0;
			rsp_top_valid  <= (count_q != '0);
			rsp_item_total <= hmq_pkg::TOTAL_W'(count_q);
			rsp_is_full    <= heap_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (req_operation == hmq_pkg::OP_CLEAR) begin
					count_q <= '0;
				end else if (!heap_full) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### design/max_heap_insert_queue.sv
// Channel  Direction  Contents
// req      in         operation (insert or clear), value
// rsp      out        accepted, top_value, top_valid, item_total, is_full
//
// A clear or a dropped insert goes from the accepting state straight to the state that loads
// the result register. An insert climbs at most log2 of HEAP_DEPTH levels toward the root and
// writes the value where it stops, at the root or below it, before the result is loaded. Each
// level is one read and one compare-and-write on the heap memory, which has one read port
// and one write port. Reset empties the heap at once; memory contents are not cleared. A
// stalled result waits in the output register while the next request is accepted and
// processed.
module max_heap_insert_queue #(
	parameter int unsigned HEAP_DEPTH = 64
) (
	input logic       clk,
	input logic       arst_n,
	hmq_req_if.sink   req,
	hmq_rsp_if.source rsp
);

	hmq_pkg::hmq_cmd_t    cmd;
	hmq_pkg::hmq_status_t status;
	logic                 ready;

	assign req.ready = ready;

	hmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.status    (status),
		.cmd       (cmd)
	);

	hmq_datapath #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_operation  (req.operation),
		.req_value      (req.value),
		.rsp_ready      (rsp.ready),
		.cmd            (cmd),
		.status         (status),
		.rsp_valid      (rsp.valid),
		.rsp_accepted   (rsp.accepted),
		.rsp_top_value  (rsp.top_value),
		.rsp_top_valid  (rsp.top_valid),
		.rsp_item_total (rsp.item_total),
		.rsp_is_full    (rsp.is_full)
	);

endmodule

### sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hmq_pkg::*;

	localparam int unsigned HEAP_DEPTH = 64;
	localparam int unsigned RANDOM_ITEMS = 2000;

	typedef struct {
		logic                      operation;
		logic signed [VALUE_W-1:0] value;
		bit                        hold_for_drain;
	} heap_request_t;

	typedef struct {
		logic                      accepted;
		logic signed [VALUE_W-1:0] top_value;
		logic                      top_valid;
		logic [TOTAL_W-1:0]        item_total;
		logic                      is_full;
	} top_report_t;

	typedef enum int {
		VAL_RANDOM,
		VAL_NEAR_ZERO,
		VAL_RISING,
		VAL_FALLING,
		VAL_EXTREME
	} value_shape_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_HALF,
		RDY_SPARSE,
		RDY_MOSTLY
	} ready_mode_t;

	logic clk;
	logic arst_n;

	hmq_req_if req();
	hmq_rsp_if rsp();

	max_heap_insert_queue #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	heap_request_t             request_q[$];
	top_report_t               top_report_q[$];
	logic signed [VALUE_W-1:0] heap_mem[HEAP_DEPTH];
	int unsigned               heap_count;
	int unsigned               mismatches;
	int unsigned               results_seen;
	int unsigned               burst_left;
	int unsigned               gap_left;
	int unsigned               hold_left;
	int unsigned               mode_left;
	ready_mode_t               ready_mode;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_INSERT;
		req.value = '0;
		rsp.ready = 1'b0;
		heap_count = 0;
		mismatches = 0;
		results_seen = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#5_000_000;
		$display("FAIL max_heap_insert_queue");
		$finish;
	end

	function automatic void add_request(input logic op, input logic signed [VALUE_W-1:0] val,
		input bit drain = 1'b0);
		heap_request_t item;
		item.operation = op;
		item.value = val;
		item.hold_for_drain = drain;
		request_q.push_back(item);
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value(input value_shape_t shape,
		input int idx, input logic signed [VALUE_W-1:0] base);
		logic signed [VALUE_W-1:0] v;
		case (shape)
			VAL_RANDOM: begin
				v = $urandom;
			end
			VAL_NEAR_ZERO: begin
				v = $urandom_range(0, 8);
				v = v - 4;
			end
			VAL_RISING: begin
				v = base + idx;
			end
			VAL_FALLING: begin
				v = base - idx;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = '0;
					default: v = -1;
				endcase
			end
		endcase
		return v;
	endfunction

	// Applies one accepted request to the local heap image and queues the report it yields.
	function automatic void apply_heap_request(input logic op,
		input logic signed [VALUE_W-1:0] val);
		top_report_t               rep;
		int unsigned               pos;
		int unsigned               up;
		logic signed [VALUE_W-1:0] swap;
		rep.accepted = 1'b1;
		if (op == OP_CLEAR) begin
			heap_count = 0;
		end else if (heap_count >= HEAP_DEPTH) begin
			rep.accepted = 1'b0;
		end else begin
			heap_mem[heap_count] = val;
			pos = heap_count;
			heap_count++;
			while (pos > 0) begin
				up = (pos - 1) / 2;
				if (heap_mem[pos] <= heap_mem[up])
					break;
				swap = heap_mem[pos];
				heap_mem[pos] = heap_mem[up];
				heap_mem[up] = swap;
				pos = up;
			end
		end
		rep.top_valid = heap_count > 0;
		rep.top_value = rep.top_valid ? heap_mem[0] : '0;
		rep.item_total = TOTAL_W'(heap_count);
		rep.is_full = heap_count == HEAP_DEPTH;
		top_report_q.push_back(rep);
	endfunction

	always @(posedge clk or negedge arst_n) begin : req_driver
		heap_request_t head;
		logic          next_valid;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.operation <= OP_INSERT;
			req.value <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (req.valid && req.ready)
				apply_heap_request(req.operation, req.value);
			if (!req.valid || req.ready) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					if (request_q.size() > 0 &&
						(!request_q[0].hold_for_drain || top_report_q.size() == 0)) begin
						head = request_q.pop_front();
						req.operation <= head.operation;
						req.value <= head.value;
						next_valid = 1'b1;
						burst_left--;
						if (burst_left == 0) begin
							burst_left = $urandom_range(1, 30);
							gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
						end
					end
				end
				req.valid <= next_valid;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		top_report_t want;
		logic        next_ready;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left = 0;
			mode_left = 0;
			ready_mode = RDY_ALWAYS;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (top_report_q.size() == 0) begin
					$error("unexpected result with no request outstanding");
					mismatches++;
				end else begin
					want = top_report_q.pop_front();
					if (rsp.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, rsp.accepted);
						mismatches++;
					end
					if (rsp.top_value !== want.top_value) begin
						$error("top_value: expected %0d, got %0d", want.top_value, rsp.top_value);
						mismatches++;
					end
					if (rsp.top_valid !== want.top_valid) begin
						$error("top_valid: expected %0d, got %0d", want.top_valid, rsp.top_valid);
						mismatches++;
					end
					if (rsp.item_total !== want.item_total) begin
						$error("item_total: expected %0d, got %0d", want.item_total,
							rsp.item_total);
						mismatches++;
					end
					if (rsp.is_full !== want.is_full) begin
						$error("is_full: expected %0d, got %0d", want.is_full, rsp.is_full);
						mismatches++;
					end
				end
				if (results_seen == 150 || results_seen == 1100)
					hold_left = 300;
			end
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(32, 200);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else begin
				case (ready_mode)
					RDY_ALWAYS: next_ready = 1'b1;
					RDY_HALF: next_ready = $urandom_range(0, 1) == 1;
					RDY_SPARSE: next_ready = $urandom_range(0, 7) == 0;
					default: next_ready = $urandom_range(0, 7) != 0;
				endcase
			end
			rsp.ready <= next_ready;
		end
	end

	initial begin : stimulus
		int unsigned               random_items;
		int unsigned               len;
		int unsigned               pick;
		value_shape_t              shape;
		logic signed [VALUE_W-1:0] base;

		add_request(OP_CLEAR, $urandom);
		add_request(OP_INSERT, 32'sh0000_0000);
		add_request(OP_INSERT, 32'sh8000_0000);
		add_request(OP_INSERT, 32'sh7fff_ffff);
		add_request(OP_INSERT, 32'sh7fff_ffff);
		add_request(OP_INSERT, -1);
		add_request(OP_INSERT, 1);
		add_request(OP_INSERT, 1);
		add_request(OP_CLEAR, '0);
		add_request(OP_INSERT, 32'sh8000_0000);
		add_request(OP_INSERT, 32'sh8000_0000);
		add_request(OP_INSERT, -2);
		add_request(OP_INSERT, 3);
		add_request(OP_INSERT, 3);
		add_request(OP_INSERT, 2);
		add_request(OP_CLEAR, '0, 1'b1);
		add_request(OP_INSERT, 32'sh5555_5555);
		add_request(OP_INSERT, 32'shaaaa_aaaa);
		add_request(OP_CLEAR, 32'shffff_ffff);
		add_request(OP_CLEAR, '0, 1'b1);

		// Most of the traffic is runs of inserts closed by a clear; about half of them are long
		// runs of 60 to 72 inserts around the capacity, so that dropped inserts are seen many times.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = $urandom_range(0, 1) ? $urandom_range(60, 72) : $urandom_range(1, 20);
				shape = value_shape_t'($urandom_range(0, 4));
				base = $urandom;
				for (int i = 0; i < len; i++)
					add_request(OP_INSERT, pick_value(shape, i, base));
				add_request(OP_CLEAR, $urandom);
				random_items += len + 1;
			end else if (pick < 95) begin
				len = $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					add_request($urandom_range(0, 1) ? OP_CLEAR : OP_INSERT, $urandom);
				random_items += len;
			end else begin
				add_request(OP_INSERT, $urandom, 1'b1);
				random_items++;
			end
		end

		@(posedge arst_n);
		@(negedge clk);
		while (request_q.size() > 0 || req.valid || top_report_q.size() > 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("PASS max_heap_insert_queue");
		else
			$display("FAIL max_heap_insert_queue");
		$finish;
	end
endmodule

### sim.f
design/hmq_pkg.sv
design/hmq_req_if.sv
design/hmq_rsp_if.sv
design/hmq_ctrl.sv
design/hmq_datapath.sv
design/max_heap_insert_queue.sv
sim/tb.sv
